// ----- hdl/lwq_pkg.sv -----
package lwq_pkg;

	localparam int LOCK_IN_W = 4;
	localparam int CLIENT_W  = 4;
	localparam int LOCK_CODES = 2 ** LOCK_IN_W;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_QUEUED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		NT_NONE   = 2'd0,
		NT_REVOKE = 2'd1,
		NT_RETRY  = 2'd2
	} notice_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_META,
		BK_RESP
	} back_state_t;

	// head of the request queue, front to back
	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	// back to front
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

endpackage

// ----- hdl/lwq_front.sv -----
module lwq_front #(
	parameter int NUM_LOCKS = 16,
	parameter int LKW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [lwq_pkg::LOCK_IN_W-1:0]  lock_num,
	input  logic [lwq_pkg::CLIENT_W-1:0]   client_num,
	output lwq_pkg::q_head_t               q_head,
	output logic [LKW-1:0]                 q_lock,
	output logic [lwq_pkg::CLIENT_W-1:0]   q_client,
	input  lwq_pkg::back_stat_t            back_stat
);

	logic [LKW-1:0] lock_map [lwq_pkg::LOCK_CODES];

	// lock number folded onto the lock range
	for (genvar i = 0; i < lwq_pkg::LOCK_CODES; i++) begin : g_map
		assign lock_map[i] = LKW'(i % NUM_LOCKS);
	end

	lwq_pkg::op_t                 op_q     [2];
	logic [LKW-1:0]               lock_q   [2];
	logic [lwq_pkg::CLIENT_W-1:0] client_q [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   count_q;
	logic                         push;

	assign busy = (count_q == 2'd2) || back_stat.clearing;
	assign push = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (back_stat.pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !back_stat.pop) count_q <= count_q + 2'd1;
			else if (!push && back_stat.pop) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]     <= lwq_pkg::op_t'(op);
			lock_q[wr_ptr_q]   <= lock_map[lock_num];
			client_q[wr_ptr_q] <= client_num;
		end
	end

	assign q_head.valid = (count_q != 2'd0);
	assign q_head.op    = op_q[rd_ptr_q];
	assign q_lock       = lock_q[rd_ptr_q];
	assign q_client     = client_q[rd_ptr_q];

endmodule

// ----- hdl/lwq_back.sv -----
module lwq_back #(
	parameter int NUM_LOCKS = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int LKW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lwq_pkg::q_head_t               q_head,
	input  logic [LKW-1:0]                 q_lock,
	input  logic [lwq_pkg::CLIENT_W-1:0]   q_client,
	output lwq_pkg::back_stat_t            back_stat,
	output logic                           done,
	output logic [1:0]                     reply_status,
	output logic [1:0]                     notice_kind,
	output logic [lwq_pkg::CLIENT_W-1:0]   notice_client,
	output logic [lwq_pkg::LOCK_IN_W-1:0]  notice_lock
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int SLOTS = NUM_LOCKS * QUEUE_DEPTH;
	localparam int AW = $clog2(SLOTS);

	function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] d;
		d = s - SW'(QUEUE_DEPTH);
		return (s >= SW'(QUEUE_DEPTH)) ? d[PW-1:0] : s[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [LKW-1:0] l,
	                                             input logic [PW-1:0] p);
		return AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
	endfunction

	logic [PW-1:0]                head_mem [NUM_LOCKS];
	logic [CW-1:0]                cnt_mem  [NUM_LOCKS];
	logic [lwq_pkg::CLIENT_W-1:0] slot_mem [SLOTS];

	lwq_pkg::back_state_t         state_q, state_d;
	logic [LKW-1:0]               clr_cnt_q;
	lwq_pkg::op_t                 op_q;
	logic [LKW-1:0]               lock_q;
	logic [lwq_pkg::CLIENT_W-1:0] client_q;
	logic [PW-1:0]                head_rd_q;
	logic [CW-1:0]                cnt_rd_q;
	logic [lwq_pkg::CLIENT_W-1:0] slot_rd_q;
	lwq_pkg::status_t             status_q, status_d;
	lwq_pkg::notice_t             kind_q, kind_d;

	logic                         pop;
	logic                         meta_we;
	logic [LKW-1:0]               meta_waddr;
	logic [PW-1:0]                head_wd;
	logic [CW-1:0]                cnt_wd;
	logic                         slot_we;
	logic [AW-1:0]                slot_waddr;
	logic [AW-1:0]                slot_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lwq_pkg::BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lwq_pkg::BK_CLEAR) clr_cnt_q <= clr_cnt_q + LKW'(1);
		end
	end

	always_comb begin
		logic [PW-1:0] nhead;
		logic [PW-1:0] tail_pos;
		logic [PW-1:0] app_pos;
		state_d    = state_q;
		pop        = 1'b0;
		meta_we    = 1'b0;
		meta_waddr = lock_q;
		head_wd    = head_rd_q;
		cnt_wd     = cnt_rd_q;
		slot_we    = 1'b0;
		status_d   = lwq_pkg::ST_OK;
		kind_d     = lwq_pkg::NT_NONE;
		nhead      = wrap(SW'(head_rd_q) + SW'(1));
		tail_pos   = wrap(SW'(head_rd_q) + SW'(cnt_rd_q) - SW'(1));
		app_pos    = wrap(SW'(head_rd_q) + SW'(cnt_rd_q));
		slot_waddr = slot_addr(lock_q, app_pos);
		slot_raddr = slot_addr(lock_q, tail_pos);
		case (state_q)
			lwq_pkg::BK_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_cnt_q;
				head_wd    = '0;
				cnt_wd     = '0;
				if (clr_cnt_q == LKW'(NUM_LOCKS - 1)) state_d = lwq_pkg::BK_IDLE;
			end
			lwq_pkg::BK_IDLE: begin
				if (q_head.valid) begin
					pop     = 1'b1;
					state_d = lwq_pkg::BK_META;
				end
			end
			lwq_pkg::BK_META: begin
				state_d = lwq_pkg::BK_RESP;
				if (op_q == lwq_pkg::OP_ACQUIRE) begin
					if (cnt_rd_q == '0) begin
						meta_we    = 1'b1;
						cnt_wd     = CW'(1);
						slot_we    = 1'b1;
						slot_waddr = slot_addr(lock_q, head_rd_q);
					end else if (cnt_rd_q >= CW'(QUEUE_DEPTH)) begin
						status_d = lwq_pkg::ST_FULL;
					end else begin
						// revoke goes to the old tail, requester lands behind it
						meta_we  = 1'b1;
						cnt_wd   = cnt_rd_q + CW'(1);
						slot_we  = 1'b1;
						status_d = lwq_pkg::ST_QUEUED;
						kind_d   = lwq_pkg::NT_REVOKE;
					end
				end else begin
					if (cnt_rd_q == '0) begin
						status_d = lwq_pkg::ST_EMPTY;
					end else begin
						meta_we    = 1'b1;
						head_wd    = nhead;
						cnt_wd     = cnt_rd_q - CW'(1);
						slot_raddr = slot_addr(lock_q, nhead);
						if (cnt_rd_q != CW'(1)) kind_d = lwq_pkg::NT_RETRY;
					end
				end
			end
			lwq_pkg::BK_RESP: begin
				// next word may start while this result is shown
				if (q_head.valid) begin
					pop     = 1'b1;
					state_d = lwq_pkg::BK_META;
				end else begin
					state_d = lwq_pkg::BK_IDLE;
				end
			end
			default: state_d = lwq_pkg::BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q      <= q_head.op;
			lock_q    <= q_lock;
			client_q  <= q_client;
			head_rd_q <= head_mem[q_lock];
			cnt_rd_q  <= cnt_mem[q_lock];
		end
		if (meta_we) begin
			head_mem[meta_waddr] <= head_wd;
			cnt_mem[meta_waddr]  <= cnt_wd;
		end
		if (slot_we) slot_mem[slot_waddr] <= client_q;
		if (state_q == lwq_pkg::BK_META) begin
			slot_rd_q <= slot_mem[slot_raddr];
			status_q  <= status_d;
			kind_q    <= kind_d;
		end
	end

	assign back_stat.pop      = pop;
	assign back_stat.clearing = (state_q == lwq_pkg::BK_CLEAR);

	assign done          = (state_q == lwq_pkg::BK_RESP);
	assign reply_status  = status_q;
	assign notice_kind   = kind_q;
	assign notice_client = (kind_q != lwq_pkg::NT_NONE) ? slot_rd_q : '0;
	assign notice_lock   = (kind_q != lwq_pkg::NT_NONE) ? lwq_pkg::LOCK_IN_W'(lock_q) : '0;

endmodule

// ----- hdl/lock_waiter_queue_manager_top.sv -----
// Lock waiter queue manager: one FIFO of client numbers per lock, head is holder.
// Request channel: a word (op, lock_num, client_num) is taken at a clock edge
// with start high and busy low. op 0 acquires, op 1 releases.
// Result channel: done is high for one cycle with reply_status, notice_kind,
// notice_client and notice_lock valid; the receiver cannot hold results off,
// so there is no back-pressure on this side.
// A two-word queue sits between the request side and the lock engine; busy
// rises when it is full.
// A lone request moves from the queue head into the engine's registers, through
// the META state, to the RESP state in which its result is shown.
// The lock engine works on one request at a time: a registered read of the
// lock's head/count memory, then a registered read of the slot memory, the
// next request's head/count read overlapping the result.
// Reset: after arst_n is released the per-lock head/count memory is cleared,
// one lock a cycle, for NUM_LOCKS cycles; busy stays high meanwhile.
// Slot contents are not cleared; an unwritten slot may be read, but notice_client then shows zero.
module lock_waiter_queue_manager_top #(
	parameter int NUM_LOCKS = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [lwq_pkg::LOCK_IN_W-1:0]  lock_num,
	input  logic [lwq_pkg::CLIENT_W-1:0]   client_num,
	output logic                           done,
	output logic [1:0]                     reply_status,
	output logic [1:0]                     notice_kind,
	output logic [lwq_pkg::CLIENT_W-1:0]   notice_client,
	output logic [lwq_pkg::LOCK_IN_W-1:0]  notice_lock
);

	localparam int LKW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

	lwq_pkg::q_head_t             q_head;
	logic [LKW-1:0]               q_lock;
	logic [lwq_pkg::CLIENT_W-1:0] q_client;
	lwq_pkg::back_stat_t          back_stat;

	lwq_front #(
		.NUM_LOCKS (NUM_LOCKS),
		.LKW       (LKW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.lock_num   (lock_num),
		.client_num (client_num),
		.q_head     (q_head),
		.q_lock     (q_lock),
		.q_client   (q_client),
		.back_stat  (back_stat)
	);

	lwq_back #(
		.NUM_LOCKS   (NUM_LOCKS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.LKW         (LKW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_head        (q_head),
		.q_lock        (q_lock),
		.q_client      (q_client),
		.back_stat     (back_stat),
		.done          (done),
		.reply_status  (reply_status),
		.notice_kind   (notice_kind),
		.notice_client (notice_client),
		.notice_lock   (notice_lock)
	);

endmodule

// ----- tb/sv/tb_lock_waiter_queue_manager_top.sv -----
`timescale 1ns / 1ps

module tb_lock_waiter_queue_manager_top;

	localparam int NUM_LOCKS   = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 150000;
	localparam int RANDOM_WORDS = 2000;

	typedef struct packed {
		lwq_pkg::status_t                status;
		lwq_pkg::notice_t                kind;
		logic [lwq_pkg::CLIENT_W-1:0]    client;
		logic [lwq_pkg::LOCK_IN_W-1:0]   lock;
	} lock_reply_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic                           op;
	logic [lwq_pkg::LOCK_IN_W-1:0]  lock_num;
	logic [lwq_pkg::CLIENT_W-1:0]   client_num;
	logic                           done;
	logic [1:0]                     reply_status;
	logic [1:0]                     notice_kind;
	logic [lwq_pkg::CLIENT_W-1:0]   notice_client;
	logic [lwq_pkg::LOCK_IN_W-1:0]  notice_lock;

	// shadow of the lock queues
	logic [lwq_pkg::CLIENT_W-1:0] waiter_mem [NUM_LOCKS][QUEUE_DEPTH];
	int unsigned                  head_pos   [NUM_LOCKS];
	int unsigned                  queued     [NUM_LOCKS];

	lock_reply_t pending_replies [$];
	int          mismatches = 0;
	int          cycle_count = 0;

	lock_waiter_queue_manager_top #(
		.NUM_LOCKS   (NUM_LOCKS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.lock_num      (lock_num),
		.client_num    (client_num),
		.done          (done),
		.reply_status  (reply_status),
		.notice_kind   (notice_kind),
		.notice_client (notice_client),
		.notice_lock   (notice_lock)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, pending_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch, cycle %0d: %s", cycle_count, what);
	endtask

	// Applies one request word to the shadow queues and returns the reply it gives.
	function automatic lock_reply_t predict_lock_reply(input lwq_pkg::op_t o,
		input logic [lwq_pkg::LOCK_IN_W-1:0] lk, input logic [lwq_pkg::CLIENT_W-1:0] cl);
		lock_reply_t r;
		int unsigned li;
		int unsigned cnt;
		int unsigned hd;
		li  = lk % NUM_LOCKS;
		cnt = queued[li];
		hd  = head_pos[li];
		r   = '{status: lwq_pkg::ST_OK, kind: lwq_pkg::NT_NONE, client: '0, lock: '0};
		if (o == lwq_pkg::OP_ACQUIRE) begin
			if (cnt == 0) begin
				waiter_mem[li][hd] = cl;
				queued[li] = 1;
			end else if (cnt >= QUEUE_DEPTH) begin
				r.status = lwq_pkg::ST_FULL;
			end else begin
				// tail gets the revoke, requester goes in behind it
				r.status = lwq_pkg::ST_QUEUED;
				r.kind   = lwq_pkg::NT_REVOKE;
				r.client = waiter_mem[li][(hd + cnt - 1) % QUEUE_DEPTH];
				r.lock   = li[lwq_pkg::LOCK_IN_W-1:0];
				waiter_mem[li][(hd + cnt) % QUEUE_DEPTH] = cl;
				queued[li] = cnt + 1;
			end
		end else begin
			if (cnt == 0) begin
				r.status = lwq_pkg::ST_EMPTY;
			end else begin
				// head popped whoever asks
				hd = (hd + 1) % QUEUE_DEPTH;
				head_pos[li] = hd;
				queued[li] = cnt - 1;
				if (cnt > 1) begin
					r.kind   = lwq_pkg::NT_RETRY;
					r.client = waiter_mem[li][hd];
					r.lock   = li[lwq_pkg::LOCK_IN_W-1:0];
				end
			end
		end
		return r;
	endfunction

	// Called just after a rising edge; returns just after the edge that took the word,
	// with start still high.
	task automatic send_request(input lwq_pkg::op_t o,
		input logic [lwq_pkg::LOCK_IN_W-1:0] lk, input logic [lwq_pkg::CLIENT_W-1:0] cl);
		start      <= 1'b1;
		op         <= o;
		lock_num   <= lk;
		client_num <= cl;
		do @(negedge clk); while (busy);
		@(posedge clk);
		pending_replies.push_back(predict_lock_reply(o, lk, cl));
	endtask

	task automatic idle_sender(input int n);
		start <= 1'b0;
		{op, lock_num, client_num} <= 9'($urandom());
		repeat (n) @(posedge clk);
	endtask

	// Sampled mid-cycle so the values are settled.
	always @(negedge clk) begin
		lock_reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with nothing pending: st=%0d nk=%0d nc=%0d nl=%0d",
					reply_status, notice_kind, notice_client, notice_lock));
			end else begin
				want = pending_replies.pop_front();
				if (reply_status !== want.status)
					flag_mismatch($sformatf("reply_status %0d, want %0d",
						reply_status, want.status));
				if (notice_kind !== want.kind)
					flag_mismatch($sformatf("notice_kind %0d, want %0d",
						notice_kind, want.kind));
				if (notice_client !== want.client)
					flag_mismatch($sformatf("notice_client %0d, want %0d",
						notice_client, want.client));
				if (notice_lock !== want.lock)
					flag_mismatch($sformatf("notice_lock %0d, want %0d",
						notice_lock, want.lock));
			end
		end
	end

	task automatic test_release_on_empty();
		send_request(lwq_pkg::OP_RELEASE, 4'd0, 4'd0);
	endtask

	task automatic test_grant_and_revoke();
		send_request(lwq_pkg::OP_ACQUIRE, 4'd0, 4'd0);
		send_request(lwq_pkg::OP_ACQUIRE, 4'd0, 4'd15);
		// same client again goes in a second time
		send_request(lwq_pkg::OP_ACQUIRE, 4'd0, 4'd15);
	endtask

	task automatic test_release_retry();
		// releaser is not the holder, head popped regardless
		send_request(lwq_pkg::OP_RELEASE, 4'd0, 4'd9);
		send_request(lwq_pkg::OP_RELEASE, 4'd0, 4'd15);
		send_request(lwq_pkg::OP_RELEASE, 4'd0, 4'd15);
		send_request(lwq_pkg::OP_RELEASE, 4'd0, 4'd0);
	endtask

	task automatic test_queue_full();
		for (int c = 0; c < QUEUE_DEPTH; c++)
			send_request(lwq_pkg::OP_ACQUIRE, 4'd15, 4'(c + 8));
		send_request(lwq_pkg::OP_ACQUIRE, 4'd15, 4'd15);
		send_request(lwq_pkg::OP_RELEASE, 4'd15, 4'd3);
		send_request(lwq_pkg::OP_ACQUIRE, 4'd15, 4'd6);
	endtask

	task automatic test_random_traffic(input int n_words);
		int acquire_pct;
		int hot_a;
		int hot_b;
		lwq_pkg::op_t o;
		logic [lwq_pkg::LOCK_IN_W-1:0] lk;
		for (int i = 0; i < n_words; i++) begin
			// new traffic mix every so often: filling, draining or balanced
			if (i % 250 == 0) begin
				acquire_pct = $urandom_range(25, 85);
				hot_a = $urandom_range(0, NUM_LOCKS - 1);
				hot_b = $urandom_range(0, NUM_LOCKS - 1);
			end
			if (!(i >= 900 && i < 1300) && $urandom_range(0, 99) < 14)
				idle_sender($urandom_range(1, 5));
			case ($urandom_range(0, 9))
				0, 1, 2: lk = 4'(hot_a);
				3, 4, 5: lk = 4'(hot_b);
				default: lk = 4'($urandom_range(0, NUM_LOCKS - 1));
			endcase
			o = ($urandom_range(0, 99) < acquire_pct) ? lwq_pkg::OP_ACQUIRE
				: lwq_pkg::OP_RELEASE;
			send_request(o, lk, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		int waited;
		for (int l = 0; l < NUM_LOCKS; l++) begin
			head_pos[l] = 0;
			queued[l] = 0;
			for (int s = 0; s < QUEUE_DEPTH; s++)
				waiter_mem[l][s] = '0;
		end
		arst_n     <= 1'b0;
		start      <= 1'b0;
		op         <= 1'b0;
		lock_num   <= '0;
		client_num <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_release_on_empty();
		test_grant_and_revoke();
		test_release_retry();
		test_queue_full();
		test_random_traffic(RANDOM_WORDS);

		start <= 1'b0;
		waited = 0;
		while (pending_replies.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_replies.size() != 0)
			flag_mismatch($sformatf("%0d replies never came", pending_replies.size()));

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
